>>> hdl/kcb_pkg.sv
// Types and constants for the keypoint context binning block.
// No dependencies; used by every file in this folder.
package kcb_pkg;

   localparam int unsigned FULL_TURN = 23040;
   localparam int unsigned BIN_MAX   = 63;
   localparam int unsigned STAGES    = 12;

   typedef enum logic [1:0] {
      CSR_RADIAL_DIVISIONS = 2'd0,
      CSR_ANGLE_BINS       = 2'd1,
      CSR_RADIUS_BINS      = 2'd2,
      CSR_UNUSED           = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [15:0] anchor_x;
      logic [15:0] anchor_y;
      logic [15:0] anchor_size;
      logic [14:0] anchor_angle;
      logic [7:0]  anchor_octave;
      logic [15:0] neighbour_x;
      logic [15:0] neighbour_y;
      logic [14:0] neighbour_angle;
      logic [7:0]  neighbour_octave;
      logic        same_point;
   } req_type;

   typedef struct packed {
      logic       pair_valid;
      logic [5:0] angle_bin;
      logic [5:0] radius_bin;
   } rsp_type;

   typedef struct packed {
      logic [6:0] radial_divisions;
      logic [6:0] angle_bins;
      logic [6:0] radius_bins;
   } cfg_type;

   typedef struct packed {
      logic        ok;
      logic [15:0] asz;
      logic [15:0] dx;
      logic [15:0] dy;
      logic [14:0] aang;
      logic [14:0] nang;
      logic [14:0] rel;
      logic [31:0] sqx;
      logic [31:0] sqy;
      logic [33:0] rad;
      logic [19:0] rem;
      logic [16:0] root;
      logic [21:0] anum;
      logic [6:0]  aq;
      logic [23:0] lhs;
      logic [22:0] rhs;
      logic [6:0]  rq;
      rsp_type     rsp;
   } pipe_type;

endpackage

>>> hdl/keypoint_context_binning.sv
// Keypoint context binning: one pair per clock, 12-stage pipeline. A request is
// taken every cycle while the result side keeps up; its result is offered from the
// last stage register. The depth is set by the 17-step square root, spread at most
// three steps per stage, followed by the limit test and a 7-step ring divider. A
// stalled result holds only the stages behind it that are full; empty stages
// keep filling. Depends on kcb_pkg.
module keypoint_context_binning (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  kcb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output kcb_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [6:0]       csr_data
);
   import kcb_pkg::*;

   cfg_type  cfg_ff;
   pipe_type p_ff [STAGES];
   pipe_type p_in [STAGES];
   logic [STAGES-1:0] v_ff;
   logic [STAGES:0]   en;

   function automatic pipe_type load(req_type r);
      pipe_type p;
      p = '0;
      p.ok  = !r.same_point && (r.anchor_octave == r.neighbour_octave);
      p.asz = r.anchor_size;
      p.dx  = (r.anchor_x >= r.neighbour_x) ? r.anchor_x - r.neighbour_x
                                            : r.neighbour_x - r.anchor_x;
      p.dy  = (r.anchor_y >= r.neighbour_y) ? r.anchor_y - r.neighbour_y
                                            : r.neighbour_y - r.anchor_y;
      p.aang = (r.anchor_angle >= 15'(FULL_TURN)) ? r.anchor_angle - 15'(FULL_TURN)
                                                  : r.anchor_angle;
      p.nang = (r.neighbour_angle >= 15'(FULL_TURN))
               ? r.neighbour_angle - 15'(FULL_TURN) : r.neighbour_angle;
      return p;
   endfunction

   function automatic pipe_type sqrt_step(pipe_type pi);
      pipe_type p;
      logic [19:0] r;
      logic [18:0] t;
      p = pi;
      r = {p.rem[17:0], p.rad[33:32]};
      t = {p.root, 2'b01};
      if (r >= {1'b0, t}) begin
         r = r - {1'b0, t};
         p.root = {p.root[15:0], 1'b1};
      end else begin
         p.root = {p.root[15:0], 1'b0};
      end
      p.rem = r;
      p.rad = {p.rad[31:0], 2'b00};
      return p;
   endfunction

   function automatic pipe_type adiv_step(pipe_type pi, int unsigned k);
      pipe_type p;
      logic [21:0] d;
      p = pi;
      d = 22'(FULL_TURN) << k;
      if (p.anum >= d) begin
         p.anum = p.anum - d;
         p.aq[3'(k)] = 1'b1;
      end
      return p;
   endfunction

   function automatic pipe_type rdiv_step(pipe_type pi, int unsigned k);
      pipe_type p;
      logic [23:0] d;
      p = pi;
      d = 24'(p.asz) << k;
      if (p.lhs >= d) begin
         p.lhs = p.lhs - d;
         p.rq[3'(k)] = 1'b1;
      end
      return p;
   endfunction

   function automatic pipe_type step(pipe_type pi, int unsigned idx, cfg_type c);
      pipe_type p;
      p = pi;
      unique case (idx)
         1: begin
            p.sqx = p.dx * p.dx;
            p.sqy = p.dy * p.dy;
            p.rel = (p.nang >= p.aang) ? p.nang - p.aang
                                       : 15'(16'(p.nang) + 16'(FULL_TURN) - 16'(p.aang));
         end
         2: begin
            p.rad  = 34'(p.sqx) + 34'(p.sqy);
            p.anum = 22'(p.rel) * 22'(c.angle_bins);
            p.rem  = '0;
            p.root = '0;
            p.aq   = '0;
            p = sqrt_step(p);
         end
         3: begin
            p = sqrt_step(sqrt_step(sqrt_step(p)));
            p = adiv_step(adiv_step(p, 6), 5);
         end
         4: begin
            p = sqrt_step(sqrt_step(sqrt_step(p)));
            p = adiv_step(adiv_step(p, 4), 3);
         end
         5: begin
            p = sqrt_step(sqrt_step(sqrt_step(p)));
            p = adiv_step(adiv_step(p, 2), 1);
         end
         6: begin
            p = sqrt_step(sqrt_step(sqrt_step(p)));
            p = adiv_step(p, 0);
         end
         7: p = sqrt_step(sqrt_step(sqrt_step(p)));
         8: p = sqrt_step(p);
         9: begin
            p.lhs = 24'(p.root) * 24'(c.radial_divisions);
            p.rhs = 23'(p.asz) * 23'(c.radius_bins);
         end
         10: begin
            p.ok = p.ok && (p.lhs < 24'(p.rhs));
            p.rq = '0;
            p = rdiv_step(rdiv_step(rdiv_step(p, 6), 5), 4);
         end
         11: begin
            p = rdiv_step(rdiv_step(rdiv_step(rdiv_step(p, 3), 2), 1), 0);
            p.rsp.pair_valid = p.ok;
            p.rsp.angle_bin  = !p.ok ? 6'd0
                               : (p.aq > 7'(BIN_MAX)) ? 6'(BIN_MAX) : p.aq[5:0];
            p.rsp.radius_bin = !p.ok ? 6'd0
                               : (p.rq > 7'(BIN_MAX)) ? 6'(BIN_MAX) : p.rq[5:0];
         end
         default: p = pi;
      endcase
      return p;
   endfunction

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{radial_divisions: 7'd10, angle_bins: 7'd16, radius_bins: 7'd16};
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_RADIAL_DIVISIONS: cfg_ff.radial_divisions <= csr_data;
            CSR_ANGLE_BINS:       cfg_ff.angle_bins       <= csr_data;
            CSR_RADIUS_BINS:      cfg_ff.radius_bins      <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      en[STAGES] = rsp_ready;
      for (int i = STAGES - 1; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   assign p_in[0] = load(req_data);
   for (genvar gi = 1; gi < STAGES; gi++) begin : g_stage
      always_comb begin
         p_in[gi] = step(p_ff[gi-1], gi, cfg_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req_valid;
         end
         for (int i = 1; i < STAGES; i++) begin
            if (en[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < STAGES; i++) begin
         if (en[i]) begin
            p_ff[i] <= p_in[i];
         end
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = v_ff[STAGES-1];
   assign rsp_data  = p_ff[STAGES-1].rsp;

endmodule

>>> hdl/kcb_checker.sv
// Port-level checks for keypoint_context_binning, bound to the top level.
// Depends on kcb_pkg.
module kcb_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input kcb_pkg::rsp_type rsp_data
);
   import kcb_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped or changed while stalled");

   a_zero_bins: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.pair_valid |->
         rsp_data.angle_bin == 6'd0 && rsp_data.radius_bin == 6'd0)
      else $error("bins not cleared on invalid pair");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result shown right after reset");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request refused with no result waiting");

endmodule

bind keypoint_context_binning kcb_checker u_kcb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

>>> verif/kcb_checker.sv
// Checker for keypoint_context_binning: follows the register writes, predicts each
// result from the accepted requests and compares it with what the block returns.
// Depends on kcb_pkg.
`timescale 1ns / 100ps

module kcb_monitor
   import kcb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_data,
   output int          errors,
   output int          pending
);

   logic [6:0] ring_div_q, sector_cnt_q, ring_cnt_q;
   rsp_type    bins_expected_q[$];

   function automatic longint unsigned floor_root(input longint unsigned v);
      longint unsigned root, trial;
      root = 0;
      for (int b = 17; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= v) root = trial;
      end
      return root;
   endfunction

   function automatic rsp_type bin_pair(input req_type r, input logic [6:0] ring_div,
                                        input logic [6:0] sector_cnt,
                                        input logic [6:0] ring_cnt);
      rsp_type         b;
      longint unsigned dx, dy, span, a_ang, n_ang, rel, abin, rbin;
      dx    = r.anchor_x > r.neighbour_x ? r.anchor_x - r.neighbour_x
                                         : r.neighbour_x - r.anchor_x;
      dy    = r.anchor_y > r.neighbour_y ? r.anchor_y - r.neighbour_y
                                         : r.neighbour_y - r.anchor_y;
      span  = floor_root(dx * dx + dy * dy);
      a_ang = r.anchor_angle % FULL_TURN;
      n_ang = r.neighbour_angle % FULL_TURN;
      b     = '0;
      b.pair_valid = !r.same_point && r.anchor_octave == r.neighbour_octave &&
                     span * ring_div < longint'(ring_cnt) * r.anchor_size;
      if (b.pair_valid) begin
         rel  = (n_ang + FULL_TURN - a_ang) % FULL_TURN;
         abin = rel * sector_cnt / FULL_TURN;
         rbin = span * ring_div / r.anchor_size;
         b.angle_bin  = 6'(abin > BIN_MAX ? BIN_MAX : abin);
         b.radius_bin = 6'(rbin > BIN_MAX ? BIN_MAX : rbin);
      end
      return b;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         ring_div_q   <= 7'd10;
         sector_cnt_q <= 7'd16;
         ring_cnt_q   <= 7'd16;
         bins_expected_q.delete();
         errors  <= 0;
         pending <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_RADIAL_DIVISIONS: ring_div_q   <= csr_data;
               CSR_ANGLE_BINS:       sector_cnt_q <= csr_data;
               CSR_RADIUS_BINS:      ring_cnt_q   <= csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            bins_expected_q = {bins_expected_q,
                               bin_pair(req_data, ring_div_q, sector_cnt_q, ring_cnt_q)};
         if (rsp_valid && rsp_ready) begin
            if (bins_expected_q.size() == 0) begin
               $error("unexpected result %p", rsp_data);
               errors <= errors + 1;
            end else begin
               want = bins_expected_q.pop_front();
               if (rsp_data.pair_valid !== want.pair_valid)
                  $error("pair_valid: expected %0d, got %0d", want.pair_valid,
                         rsp_data.pair_valid);
               if (rsp_data.angle_bin !== want.angle_bin)
                  $error("angle_bin: expected %0d, got %0d", want.angle_bin,
                         rsp_data.angle_bin);
               if (rsp_data.radius_bin !== want.radius_bin)
                  $error("radius_bin: expected %0d, got %0d", want.radius_bin,
                         rsp_data.radius_bin);
               if (rsp_data !== want) errors <= errors + 1;
            end
         end
         pending <= bins_expected_q.size();
      end
   end

endmodule

>>> verif/tb.sv
// Testbench top for keypoint_context_binning: clock, reset, request and register
// stimulus with random idling, and the verdict. Depends on kcb_pkg and kcb_monitor.
`timescale 1ns / 100ps

module tb;
   import kcb_pkg::*;

   logic       clock = 0;
   logic       reset = 1;
   logic       req_valid = 0;
   logic       req_ready;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_ready = 0;
   rsp_type    rsp_data;
   logic       csr_valid = 0;
   logic       csr_ready;
   logic [1:0] csr_index = '0;
   logic [6:0] csr_data = '0;
   int         errors, pending;
   int         burst_left = 0;
   int         idle_cycles = 0;
   bit         hold_go = 0;

   always #1 clock = ~clock;

   keypoint_context_binning uut (.*);
   kcb_monitor u_check (.*);

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 4000) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      int hold_cnt, pat_cnt, pat_mode;
      hold_cnt = 0;
      pat_cnt  = 0;
      pat_mode = 0;
      forever begin
         @(negedge clock);
         if (hold_go) begin
            hold_go  = 0;
            hold_cnt = 300;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_ready <= 0;
         end else begin
            if (pat_cnt == 0) begin
               pat_cnt  = $urandom_range(8, 80);
               pat_mode = $urandom_range(0, 3);
            end
            pat_cnt--;
            case (pat_mode)
               0: rsp_ready <= 1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= $urandom_range(0, 7) != 0;
               default: rsp_ready <= $urandom_range(0, 3) == 0;
            endcase
         end
      end
   end

   task automatic offer(input req_type r);
      req_data  <= r;
      req_valid <= 1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      if (burst_left == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = $urandom_range(0, 3) == 0 ? 200 : $urandom_range(1, 20);
      end else begin
         burst_left--;
      end
   endtask

   task automatic drain();
      req_valid <= 0;
      while (pending != 0) @(negedge clock);
      repeat (16) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [6:0] value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   function automatic req_type pair_of(input int ax, ay, asz, aang, aoct,
                                       input int nx, ny, nang, noct, same);
      req_type r;
      r.anchor_x = 16'(ax);          r.anchor_y = 16'(ay);
      r.anchor_size = 16'(asz);      r.anchor_angle = 15'(aang);
      r.anchor_octave = 8'(aoct);    r.neighbour_x = 16'(nx);
      r.neighbour_y = 16'(ny);       r.neighbour_angle = 15'(nang);
      r.neighbour_octave = 8'(noct);
      r.same_point = 1'(same);
      return r;
   endfunction

   function automatic int step_from(input int base, input int off);
      int v;
      v = $urandom_range(0, 1) ? base + off : base - off;
      if (v > 65535) v = base - off;
      if (v < 0) v = base + off;
      if (v > 65535) v = 65535;
      return v;
   endfunction

   function automatic req_type random_pair(input logic [6:0] ring_div,
                                           input logic [6:0] ring_cnt);
      req_type         r;
      longint unsigned reach;
      int              sel;
      r.anchor_x = 16'($urandom);          r.anchor_y = 16'($urandom);
      r.anchor_size = 16'($urandom);       r.anchor_angle = 15'($urandom);
      r.anchor_octave = 8'($urandom);      r.neighbour_x = 16'($urandom);
      r.neighbour_y = 16'($urandom);       r.neighbour_angle = 15'($urandom);
      r.neighbour_octave = 8'($urandom);   r.same_point = 1'($urandom);
      if ($urandom_range(0, 99) < 80) begin
         r.neighbour_octave = r.anchor_octave;
         r.same_point = $urandom_range(0, 19) == 0;
         sel = $urandom_range(0, 99);
         r.anchor_size = 16'(sel < 3 ? 0 : sel < 70 ? $urandom_range(1, 2047)
                                                    : $urandom_range(1, 65535));
         reach = longint'(r.anchor_size) * (ring_cnt == 0 ? 1 : ring_cnt) /
                 (ring_div == 0 ? 1 : ring_div);
         reach = reach + reach / 4 + 1;
         if (reach > 65535) reach = 65535;
         r.neighbour_x = 16'(step_from(int'(r.anchor_x),
                                       int'($urandom_range(0, 32'(reach)))));
         r.neighbour_y = 16'(step_from(int'(r.anchor_y),
                                       int'($urandom_range(0, 32'(reach)))));
      end
      return r;
   endfunction

   initial begin
      logic [6:0] cfg_set[7][3] = '{'{10, 16, 16}, '{1, 1, 1}, '{64, 64, 64},
                                   '{0, 0, 0}, '{127, 127, 127}, '{0, 5, 64},
                                   '{3, 37, 9}};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      offer(pair_of(100, 100, 160, 0, 0, 100, 100, 0, 0, 0));
      offer(pair_of(100, 100, 160, 0, 0, 100, 100, 0, 0, 1));
      offer(pair_of(500, 500, 160, 0, 8'h80, 510, 500, 0, 8'h7F, 0));
      offer(pair_of(500, 500, 0, 0, 3, 500, 500, 0, 3, 0));
      offer(pair_of(0, 0, 65535, 0, 255, 65535, 65535, 23039, 255, 0));
      offer(pair_of(65535, 65535, 65535, 23039, 255, 0, 0, 0, 255, 0));
      offer(pair_of(1000, 1000, 10, 0, 1, 1160, 1000, 100, 1, 0));
      offer(pair_of(1000, 1000, 10, 0, 1, 1159, 1000, 100, 1, 0));
      offer(pair_of(1000, 1000, 10, 0, 1, 1000, 841, 100, 1, 0));
      offer(pair_of(2000, 2000, 1, 0, 0, 2000, 2000, 32767, 0, 0));
      offer(pair_of(2000, 2000, 1, 32767, 0, 2000, 2000, 0, 0, 0));
      offer(pair_of(2000, 2000, 1, 23040, 0, 2000, 2000, 23039, 0, 0));
      offer(pair_of(2000, 2000, 1, 1, 0, 2000, 2000, 0, 0, 0));
      offer(pair_of(30000, 30000, 4000, 11520, 7, 33000, 34000, 5760, 7, 0));
      offer(pair_of(30000, 30000, 65535, 0, 7, 0, 65535, 17280, 7, 0));
      offer(pair_of(0, 0, 1, 0, 0, 0, 0, 0, 0, 0));
      offer(pair_of(65535, 65535, 65535, 32767, 255, 65535, 65535, 32767, 255, 1));
      drain();

      for (int ph = 0; ph < 7; ph++) begin
         write_reg(CSR_RADIAL_DIVISIONS, cfg_set[ph][0]);
         write_reg(CSR_ANGLE_BINS, cfg_set[ph][1]);
         write_reg(CSR_RADIUS_BINS, cfg_set[ph][2]);
         if (ph == 3) write_reg(CSR_UNUSED, 7'h7F);
         if (ph == 2) begin
            hold_go    = 1;
            burst_left = 300;
         end
         for (int i = 0; i < 270; i++) begin
            offer(random_pair(cfg_set[ph][0], cfg_set[ph][2]));
            if (i == 135) drain();
         end
         drain();
      end

      if (errors == 0 && pending == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

>>> keypoint_context_binning.f
hdl/kcb_pkg.sv
hdl/keypoint_context_binning.sv
hdl/kcb_checker.sv
verif/kcb_checker.sv
verif/tb.sv
